### src/ft_wrench_gravity_compensation_core_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef FT_WRENCH_GRAVITY_COMPENSATION_CORE_ASSERT_SVH
`define FT_WRENCH_GRAVITY_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FTGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ftgc_pkg.sv
`default_nettype none

package ftgc_pkg;

  // 9.81 in unsigned Q4.16, rounded
  localparam logic [19:0] GRAV_Q16 = 20'd642908;

  localparam int QDEPTH_DEF = 4;

  localparam logic [47:0] CAL_RESET = 48'd16384;

  localparam logic [2:0] CFG_CAL_FX   = 3'd0;
  localparam logic [2:0] CFG_CAL_FY   = 3'd1;
  localparam logic [2:0] CFG_CAL_FZ   = 3'd2;
  localparam logic [2:0] CFG_CAL_TX   = 3'd3;
  localparam logic [2:0] CFG_CAL_TY   = 3'd4;
  localparam logic [2:0] CFG_CAL_TZ   = 3'd5;
  localparam logic [2:0] CFG_MASS     = 3'd6;
  localparam logic [2:0] CFG_MOMENT   = 3'd7;

  localparam logic [1:0] KIND_FULL = 2'd0;
  localparam logic [1:0] KIND_TOOL = 2'd1;
  localparam logic [1:0] KIND_EXT  = 2'd2;

  typedef struct packed {
    logic signed [31:0] raw_force_x;
    logic signed [31:0] raw_force_y;
    logic signed [31:0] raw_force_z;
    logic signed [31:0] raw_torque_x;
    logic signed [31:0] raw_torque_y;
    logic signed [31:0] raw_torque_z;
    logic signed [15:0] gravity_dir_x;
    logic signed [15:0] gravity_dir_y;
    logic signed [15:0] gravity_dir_z;
    logic               transform_ok;
  } in_payload_t;

  typedef struct packed {
    logic [1:0]         wrench_kind;
    logic signed [31:0] out_force_x;
    logic signed [31:0] out_force_y;
    logic signed [31:0] out_force_z;
    logic signed [31:0] out_torque_x;
    logic signed [31:0] out_torque_y;
    logic signed [31:0] out_torque_z;
    logic               wrench_valid;
    logic               last_of_sample;
  } out_payload_t;

  // one sample between front and back: axis order fx fy fz tx ty tz
  typedef struct packed {
    logic [5:0][31:0] full;
    logic [5:0][31:0] tool;
    logic             ok;
  } qentry_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round to nearest (halves up), drop sh fraction bits, clamp
  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v,
                                                 input int unsigned sh);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (sh - 1));
    t = t >>> sh;
    return sat32(t);
  endfunction

endpackage

`default_nettype wire

### src/ft_wrench_gravity_compensation_core.sv
// A sample passes the input, product, rounding and torque-product registers,
// the queue and the result register, which sends the full, tool and
// external results in that order. Throughput is bounded by the single result
// register that carries three results per sample; in_stall rises once QDEPTH samples
// are in flight (front pipeline plus queue). Reset: synchronous, active low;
// clears the pipeline, queue and output, and loads calibration defaults.
`default_nettype none
`include "ft_wrench_gravity_compensation_core_assert.svh"

module ft_wrench_gravity_compensation_core #(
  parameter int QDEPTH = ftgc_pkg::QDEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [62:0]            cfg_wdata,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire ftgc_pkg::in_payload_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output ftgc_pkg::out_payload_t      out_data
);
  import ftgc_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  logic          take;
  logic          push;
  qentry_t       push_data;
  logic          q_pop;
  logic          q_empty;
  qentry_t       q_head;
  logic [CW-1:0] credit_r, credit_nxt;

  // samples in flight, taken until their external result leaves the queue
  assign in_stall = (credit_r == CW'(QDEPTH));
  assign take     = in_valid && !in_stall;

  always_comb begin
    credit_nxt = credit_r;
    if (take && !q_pop) begin
      credit_nxt = credit_r + 1'b1;
    end else if (q_pop && !take) begin
      credit_nxt = credit_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

  ftgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .take_data (in_data),
    .push      (push),
    .push_data (push_data)
  );

  ftgc_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  ftgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `FTGC_ASSERT_NOW(a_credit_bound, 1'b1, credit_r <= CW'(QDEPTH), "credit count overflow")
  `FTGC_ASSERT_NOW(a_pop_has_credit, q_pop, credit_r != '0, "queue pop without a sample in flight")
  `FTGC_ASSERT_NOW(a_last_is_ext, out_valid && out_data.last_of_sample,
                   out_data.wrench_kind == KIND_EXT, "last result is not the external wrench")
  `FTGC_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.wrench_valid,
                   out_data.out_force_x == '0 && out_data.out_torque_z == '0,
                   "invalid wrench carries nonzero data")
  `FTGC_ASSERT_NXT(a_ext_follows_tool,
                   out_valid && !out_stall && out_data.wrench_kind == KIND_TOOL,
                   !out_valid || out_data.wrench_kind == KIND_EXT,
                   "tool result not followed by external result")

endmodule

`default_nettype wire

### src/ftgc_front.sv
`default_nettype none

module ftgc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [62:0]           cfg_wdata,
  input  wire logic                  take,
  input  wire ftgc_pkg::in_payload_t take_data,
  output logic                       push,
  output ftgc_pkg::qentry_t          push_data
);
  import ftgc_pkg::*;

  logic [47:0] cal_r [6];
  logic [23:0] mass_r;
  logic [62:0] moment_r;
  logic [43:0] mg_r;

  // stage 0: input register
  logic        s0_valid_r;
  in_payload_t s0_data_r;

  // stage 1: products
  logic               s1_valid_r;
  logic               s1_ok_r;
  logic signed [49:0] fprod_r [6];
  logic signed [60:0] gprod_r [3];
  logic signed [36:0] xprod_r [6];

  // stage 2: rounded full wrench and tool force, cross product
  logic               s2_valid_r;
  logic               s2_ok_r;
  logic [5:0][31:0]   s2_full_r;
  logic [2:0][31:0]   s2_tforce_r;
  logic signed [37:0] cross_r [3];

  // stage 3: torque products
  logic               s3_valid_r;
  logic               s3_ok_r;
  logic [5:0][31:0]   s3_full_r;
  logic [2:0][31:0]   s3_tforce_r;
  logic signed [58:0] tprod_r [3];

  logic signed [31:0] raw_a [6];
  logic signed [15:0] u_a [3];
  logic signed [20:0] s_a [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        cal_r[i] <= CAL_RESET;
      end
      mass_r   <= '0;
      moment_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_FX: cal_r[0] <= cfg_wdata[47:0];
        CFG_CAL_FY: cal_r[1] <= cfg_wdata[47:0];
        CFG_CAL_FZ: cal_r[2] <= cfg_wdata[47:0];
        CFG_CAL_TX: cal_r[3] <= cfg_wdata[47:0];
        CFG_CAL_TY: cal_r[4] <= cfg_wdata[47:0];
        CFG_CAL_TZ: cal_r[5] <= cfg_wdata[47:0];
        CFG_MASS:   mass_r   <= cfg_wdata[23:0];
        CFG_MOMENT: moment_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // mass times g depends on config only; settles while the block is idle
  always_ff @(posedge clk) begin
    mg_r <= {20'd0, mass_r} * {24'd0, GRAV_Q16};
  end

  assign raw_a[0] = s0_data_r.raw_force_x;
  assign raw_a[1] = s0_data_r.raw_force_y;
  assign raw_a[2] = s0_data_r.raw_force_z;
  assign raw_a[3] = s0_data_r.raw_torque_x;
  assign raw_a[4] = s0_data_r.raw_torque_y;
  assign raw_a[5] = s0_data_r.raw_torque_z;
  assign u_a[0]   = s0_data_r.gravity_dir_x;
  assign u_a[1]   = s0_data_r.gravity_dir_y;
  assign u_a[2]   = s0_data_r.gravity_dir_z;
  assign s_a[0]   = $signed(moment_r[20:0]);
  assign s_a[1]   = $signed(moment_r[41:21]);
  assign s_a[2]   = $signed(moment_r[62:42]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= take;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s0_data_r <= take_data;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [32:0] diff;
    for (int i = 0; i < 6; i++) begin
      diff = {raw_a[i][31], raw_a[i]} - {cal_r[i][47], cal_r[i][47:16]};
      fprod_r[i] <= diff * $signed({1'b0, cal_r[i][15:0]});
    end
    for (int j = 0; j < 3; j++) begin
      gprod_r[j] <= $signed({1'b0, mg_r}) * u_a[j];
    end
    xprod_r[0] <= s_a[1] * u_a[2];
    xprod_r[1] <= s_a[2] * u_a[1];
    xprod_r[2] <= s_a[2] * u_a[0];
    xprod_r[3] <= s_a[0] * u_a[2];
    xprod_r[4] <= s_a[0] * u_a[1];
    xprod_r[5] <= s_a[1] * u_a[0];
    s1_ok_r    <= s0_data_r.transform_ok;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      s2_full_r[i] <= rnd_sat(64'(fprod_r[i]), 14);
    end
    for (int j = 0; j < 3; j++) begin
      s2_tforce_r[j] <= s1_ok_r ? rnd_sat(64'(gprod_r[j]), 30) : '0;
      cross_r[j]     <= 38'(xprod_r[2*j]) - 38'(xprod_r[2*j+1]);
    end
    s2_ok_r <= s1_ok_r;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      tprod_r[j] <= cross_r[j] * $signed({1'b0, GRAV_Q16});
    end
    s3_full_r   <= s2_full_r;
    s3_tforce_r <= s2_tforce_r;
    s3_ok_r     <= s2_ok_r;
  end

  always_comb begin
    push_data.full = s3_full_r;
    push_data.ok   = s3_ok_r;
    for (int j = 0; j < 3; j++) begin
      push_data.tool[j]     = s3_tforce_r[j];
      push_data.tool[3 + j] = s3_ok_r ? rnd_sat(64'(tprod_r[j]), 26) : '0;
    end
  end

  assign push = s3_valid_r;

endmodule

`default_nettype wire

### src/ftgc_fifo.sv
`default_nettype none

module ftgc_fifo #(
  parameter int DEPTH = ftgc_pkg::QDEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ftgc_pkg::qentry_t push_data,
  input  wire logic              pop,
  output logic                   empty,
  output ftgc_pkg::qentry_t      head
);
  import ftgc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qentry_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

### src/ftgc_back.sv
`default_nettype none

module ftgc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire ftgc_pkg::qentry_t  q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ftgc_pkg::out_payload_t  out_data
);
  import ftgc_pkg::*;

  typedef enum logic [2:0] {
    PH_FULL = 3'b001,
    PH_TOOL = 3'b010,
    PH_EXT  = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_payload_t     out_data_r, out_data_nxt;
  logic             load;
  logic [5:0][31:0] ext;
  logic [5:0][31:0] sel;

  always_comb begin
    logic signed [32:0] sum;
    for (int i = 0; i < 6; i++) begin
      sum    = {q_head.full[i][31], q_head.full[i]} + {q_head.tool[i][31], q_head.tool[i]};
      ext[i] = q_head.ok ? sat32(64'(sum)) : '0;
    end
  end

  assign load  = !out_valid_r || !out_stall;
  assign q_pop = load && !q_empty && (phase_r == PH_EXT);

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sel           = q_head.full;
    if (load) begin
      out_valid_nxt = !q_empty;
      out_data_nxt.wrench_valid   = 1'b1;
      out_data_nxt.last_of_sample = 1'b0;
      case (phase_r)
        PH_FULL: begin
          out_data_nxt.wrench_kind = KIND_FULL;
          sel = q_head.full;
        end
        PH_TOOL: begin
          out_data_nxt.wrench_kind  = KIND_TOOL;
          out_data_nxt.wrench_valid = q_head.ok;
          sel = q_head.tool;
        end
        PH_EXT: begin
          out_data_nxt.wrench_kind    = KIND_EXT;
          out_data_nxt.wrench_valid   = q_head.ok;
          out_data_nxt.last_of_sample = 1'b1;
          sel = ext;
        end
        default: begin
          out_data_nxt.wrench_kind = KIND_FULL;
        end
      endcase
      out_data_nxt.out_force_x  = sel[0];
      out_data_nxt.out_force_y  = sel[1];
      out_data_nxt.out_force_z  = sel[2];
      out_data_nxt.out_torque_x = sel[3];
      out_data_nxt.out_torque_y = sel[4];
      out_data_nxt.out_torque_z = sel[5];
      if (!q_empty) begin
        case (phase_r)
          PH_FULL: phase_nxt = PH_TOOL;
          PH_TOOL: phase_nxt = PH_EXT;
          PH_EXT:  phase_nxt = PH_FULL;
          default: phase_nxt = PH_FULL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FULL;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
